/* rtl/core/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and byte codes of the comment scanner.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int FIELD_BITS          = 32;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   localparam logic KIND_LINE  = 1'b0;
   localparam logic KIND_BLOCK = 1'b1;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       is_final;
   } byte_word_type;

   typedef struct packed {
      logic                  comment_kind;
      logic [FIELD_BITS-1:0] head_offset;
      logic [FIELD_BITS-1:0] tail_offset;
      logic [FIELD_BITS-1:0] start_line;
      logic [FIELD_BITS-1:0] start_column;
      logic                  closed;
      logic                  code_before;
   } result_word_type;

   typedef struct packed {
      logic            valid;
      result_word_type word;
   } result_flow_type;

endpackage

/* rtl/core/csc_req_if.sv */
// ----------------------------------------------------------------------------
// csc_req_if
// Source byte channel: valid, ready and one byte word.
// ----------------------------------------------------------------------------
interface csc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       is_final;

   modport source (output valid, output byte_in, output is_final, input ready);
   modport sink   (input valid, input byte_in, input is_final, output ready);
endinterface

/* rtl/core/csc_rsp_if.sv */
// ----------------------------------------------------------------------------
// csc_rsp_if
// Comment report channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface csc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           comment_kind;
   logic [csc_pkg::FIELD_BITS-1:0] head_offset;
   logic [csc_pkg::FIELD_BITS-1:0] tail_offset;
   logic [csc_pkg::FIELD_BITS-1:0] start_line;
   logic [csc_pkg::FIELD_BITS-1:0] start_column;
   logic                           closed;
   logic                           code_before;

   modport source (output valid, output comment_kind, output head_offset,
                   output tail_offset, output start_line, output start_column,
                   output closed, output code_before, input ready);
   modport sink   (input valid, input comment_kind, input head_offset,
                   input tail_offset, input start_line, input start_column,
                   input closed, input code_before, output ready);
endinterface

/* rtl/core/csc_in_stage.sv */
// ----------------------------------------------------------------------------
// csc_in_stage
// Input register: holds one source byte word until the scanner takes it.
// ----------------------------------------------------------------------------
module csc_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   csc_req_if.sink                req_if,
   input  logic                   consume,
   output logic                   word_valid,
   output csc_pkg::byte_word_type word
);

   logic                   valid_ff;
   logic                   valid_in;
   csc_pkg::byte_word_type word_ff;
   logic                   take;

   assign req_if.ready = !valid_ff || consume;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         word_ff.byte_in  <= req_if.byte_in;
         word_ff.is_final <= req_if.is_final;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

/* rtl/core/csc_scan_core.sv */
// ----------------------------------------------------------------------------
// csc_scan_core
// Scanner state and per-byte update; forms a report when a comment ends.
// ----------------------------------------------------------------------------
module csc_scan_core #(
   parameter int OFFSET_BITS = csc_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     word_valid,
   input  csc_pkg::byte_word_type   word,
   input  logic                     out_free,
   output logic                     consume,
   output csc_pkg::result_flow_type result
);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_STR    = 3'd2,
      MODE_ESC    = 3'd3,
      MODE_LINE   = 3'd4,
      MODE_BLOCK  = 3'd5,
      MODE_BSTAR  = 3'd6
   } mode_type;

   typedef logic [OFFSET_BITS-1:0] count_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : count_type'(v + 1'b1);
   endfunction

   function automatic logic [csc_pkg::FIELD_BITS-1:0] to_field(input count_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return (|wide[63:csc_pkg::FIELD_BITS]) ? '1 : wide[csc_pkg::FIELD_BITS-1:0];
   endfunction

   mode_type  mode_ff,        mode_in;
   count_type offset_ff,      offset_in;
   count_type line_ff,        line_in;
   count_type line_start_ff,  line_start_in;
   count_type cstart_off_ff,  cstart_off_in;
   count_type cstart_line_ff, cstart_line_in;
   count_type cstart_col_ff,  cstart_col_in;
   logic      content_ff,     content_in;
   logic      code_before_ff, code_before_in;

   logic       emit;
   logic       as_normal;
   logic       is_ws;
   logic [7:0] b;
   logic       fin;

   assign b     = word.byte_in;
   assign fin   = word.is_final;
   assign is_ws = (b == csc_pkg::CHAR_SPACE) ||
                  ((b >= csc_pkg::CHAR_TAB) && (b <= csc_pkg::CHAR_CR));

   always_comb begin
      mode_in        = mode_ff;
      offset_in      = sat_inc(offset_ff);
      line_in        = line_ff;
      line_start_in  = line_start_ff;
      cstart_off_in  = cstart_off_ff;
      cstart_line_in = cstart_line_ff;
      cstart_col_in  = cstart_col_ff;
      content_in     = content_ff;
      code_before_in = code_before_ff;
      emit           = 1'b0;
      as_normal      = 1'b0;
      result.valid             = 1'b0;
      result.word.comment_kind = csc_pkg::KIND_LINE;
      result.word.head_offset  = to_field(cstart_off_ff);
      result.word.tail_offset  = to_field(offset_ff);
      result.word.start_line   = to_field(cstart_line_ff);
      result.word.start_column = to_field(cstart_col_ff);
      result.word.closed       = 1'b1;
      result.word.code_before  = code_before_ff;

      unique case (mode_ff)
         MODE_SLASH: begin
            if (b == csc_pkg::CHAR_SLASH) begin
               mode_in = MODE_LINE;
            end else if (b == csc_pkg::CHAR_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               as_normal = 1'b1;
            end
         end
         MODE_STR: begin
            if (b == csc_pkg::CHAR_QUOTE) begin
               mode_in = MODE_NORMAL;
            end else if (b == csc_pkg::CHAR_BACKSLASH) begin
               mode_in = MODE_ESC;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_STR;
         end
         MODE_LINE: begin
            if (b == csc_pkg::CHAR_NEWLINE) begin
               emit    = 1'b1;
               mode_in = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (b == csc_pkg::CHAR_STAR) begin
               mode_in = MODE_BSTAR;
            end
         end
         MODE_BSTAR: begin
            if (b == csc_pkg::CHAR_SLASH) begin
               emit    = 1'b1;
               mode_in = MODE_NORMAL;
               result.word.comment_kind = csc_pkg::KIND_BLOCK;
               result.word.tail_offset  = to_field(sat_inc(offset_ff));
            end else if (b != csc_pkg::CHAR_STAR) begin
               mode_in = MODE_BLOCK;
            end
         end
         default: begin
            as_normal = 1'b1;
         end
      endcase

      if (as_normal) begin
         if (b == csc_pkg::CHAR_QUOTE) begin
            mode_in = MODE_STR;
         end else if (b == csc_pkg::CHAR_SLASH) begin
            mode_in        = MODE_SLASH;
            cstart_off_in  = offset_ff;
            cstart_line_in = line_ff;
            cstart_col_in  = (offset_ff >= line_start_ff) ?
                             sat_inc(count_type'(offset_ff - line_start_ff)) :
                             count_type'(1);
            code_before_in = content_ff;
         end else begin
            mode_in = MODE_NORMAL;
         end
      end

      if (fin && !emit) begin
         if (mode_in == MODE_LINE) begin
            emit = 1'b1;
            result.word.tail_offset = to_field(sat_inc(offset_ff));
         end else if (mode_in == MODE_BLOCK || mode_in == MODE_BSTAR) begin
            emit = 1'b1;
            result.word.comment_kind = csc_pkg::KIND_BLOCK;
            result.word.tail_offset  = to_field(sat_inc(offset_ff));
            result.word.closed       = 1'b0;
         end
      end

      if (b == csc_pkg::CHAR_NEWLINE) begin
         line_in       = sat_inc(line_ff);
         line_start_in = sat_inc(offset_ff);
         content_in    = 1'b0;
      end else if (!is_ws) begin
         content_in = 1'b1;
      end

      if (fin) begin
         mode_in        = MODE_NORMAL;
         offset_in      = '0;
         line_in        = count_type'(1);
         line_start_in  = '0;
         cstart_off_in  = '0;
         cstart_line_in = count_type'(1);
         cstart_col_in  = count_type'(1);
         content_in     = 1'b0;
         code_before_in = 1'b0;
      end

      result.valid = word_valid && emit;
   end

   assign consume = word_valid && (!emit || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NORMAL;
         offset_ff      <= '0;
         line_ff        <= count_type'(1);
         line_start_ff  <= '0;
         cstart_off_ff  <= '0;
         cstart_line_ff <= count_type'(1);
         cstart_col_ff  <= count_type'(1);
         content_ff     <= 1'b0;
         code_before_ff <= 1'b0;
      end else if (consume) begin
         mode_ff        <= mode_in;
         offset_ff      <= offset_in;
         line_ff        <= line_in;
         line_start_ff  <= line_start_in;
         cstart_off_ff  <= cstart_off_in;
         cstart_line_ff <= cstart_line_in;
         cstart_col_ff  <= cstart_col_in;
         content_ff     <= content_in;
         code_before_ff <= code_before_in;
      end
   end

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      consume && fin |=> offset_ff == '0 && mode_ff == MODE_NORMAL &&
                         line_ff == count_type'(1))
      else $error("scanner state not restarted after final byte");

   a_offset_advances: assert property (@(posedge clock) disable iff (reset)
      consume && !fin && offset_ff != '1 |=> offset_ff == $past(offset_ff) + 1'b1)
      else $error("byte offset did not advance");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      result.valid && !out_free |-> !consume)
      else $error("report dropped while output is full");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      word_valid && !consume |=> $stable(offset_ff) && $stable(mode_ff))
      else $error("scanner state moved without taking a byte");

endmodule

/* rtl/core/csc_out_stage.sv */
// ----------------------------------------------------------------------------
// csc_out_stage
// Result register: holds one report word until the receiver takes it.
// ----------------------------------------------------------------------------
module csc_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  csc_pkg::result_flow_type result,
   input  logic                     consume,
   output logic                     out_free,
   csc_rsp_if.source                rsp_if
);

   logic                     valid_ff;
   logic                     valid_in;
   csc_pkg::result_word_type word_ff;
   logic                     load;

   assign out_free = !valid_ff || rsp_if.ready;
   assign load     = result.valid && consume;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         word_ff <= result.word;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.comment_kind = word_ff.comment_kind;
   assign rsp_if.head_offset  = word_ff.head_offset;
   assign rsp_if.tail_offset  = word_ff.tail_offset;
   assign rsp_if.start_line   = word_ff.start_line;
   assign rsp_if.start_column = word_ff.start_column;
   assign rsp_if.closed       = word_ff.closed;
   assign rsp_if.code_before  = word_ff.code_before;

endmodule

/* rtl/core/c_style_comment_scanner_top.sv */
// ----------------------------------------------------------------------------
// c_style_comment_scanner_top
// Finds line and block comments in a byte stream, skipping quoted strings.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one source byte per word plus is_final on the last byte
//   of a text. rsp_if carries one report word per comment: kind, start and
//   end offsets, start line and column, closed and code_before.
//   A byte is registered in the input register on acceptance and scanned
//   from there; its report is registered in the result register, which
//   drives rsp_if. Throughput is one byte per cycle, set by the state
//   update between the input register and the result register, unless a
//   byte that produces a report waits for a held report.
//   The byte after is_final starts a new text with offset 0, line 1.
//   Reset clears the scanner state and the valid flags of both stage registers.
//   When rsp_if stalls with a report held, a byte that closes another
//   comment waits in the input register and req_if.ready drops; bytes that
//   produce no report keep flowing while the held report waits.
// ----------------------------------------------------------------------------
module c_style_comment_scanner_top #(
   parameter int OFFSET_BITS = csc_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   csc_req_if.sink   req_if,
   csc_rsp_if.source rsp_if
);

   logic                     word_valid;
   csc_pkg::byte_word_type   word;
   logic                     consume;
   logic                     out_free;
   csc_pkg::result_flow_type result;

   csc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .consume    (consume),
      .word_valid (word_valid),
      .word       (word)
   );

   csc_scan_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .word_valid (word_valid),
      .word       (word),
      .out_free   (out_free),
      .consume    (consume),
      .result     (result)
   );

   csc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .consume  (consume),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

endmodule
